// ===== rtl/core/heightmap_vertex_normals_assert.svh =====
// ----------------------------------------------------------------------------
// heightmap_vertex_normals assertion macros
// shared macros for the concurrent checks of the vertex normal block
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_VERTEX_NORMALS_ASSERT_SVH
`define HEIGHTMAP_VERTEX_NORMALS_ASSERT_SVH

// generic clocked check with asynchronous active-low reset
`define HVN_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// same check on the block's own clock and reset
`define HVN_ASSERT_CLK(lbl, prop, msg) \
  `HVN_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/core/hvn_pkg.sv =====
// ----------------------------------------------------------------------------
// hvn_pkg
// shared types, constants and helpers of the heightmap vertex normal block
// ----------------------------------------------------------------------------
`default_nettype none

package hvn_pkg;

  localparam int MAX_RES     = 64;
  localparam int ROW_SLOTS   = MAX_RES + 1;
  localparam int STORE_DEPTH = 3 * ROW_SLOTS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam int COORD_W   = 7;
  localparam int H_W       = 24;
  localparam int SP_W      = 23;
  localparam int V_W       = 16;
  localparam int CFG_W     = 23;
  localparam int CFG_IDX_W = 1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_GRID_RES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPACING  = 1'd1;

  localparam logic [COORD_W-1:0] GRID_RES_RESET = 7'd64;
  localparam logic [SP_W-1:0]    SPACING_RESET  = 23'd512;

  typedef logic [1:0] slot_t;

  // one vertex to be worked out
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] z;
    slot_t              zslot;
    logic [COORD_W-1:0] res;
    logic               fin;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

  function automatic slot_t slot_inc(slot_t s);
    return (s == 2'd2) ? 2'd0 : s + 2'd1;
  endfunction

  function automatic slot_t slot_dec(slot_t s);
    return (s == 2'd0) ? 2'd2 : s - 2'd1;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_addr(slot_t s, logic [COORD_W-1:0] x);
    return ADDR_W'(s) * ADDR_W'(ROW_SLOTS) + ADDR_W'(x);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/heightmap_vertex_normals.sv =====
// ----------------------------------------------------------------------------
// heightmap_vertex_normals
// central-difference normal, tangent and bitangent per heightmap vertex
// ----------------------------------------------------------------------------
// Heights arrive in raster order (row 0 first, column 0 first) on a valid/stall
// channel; each vertex leaves with its Q1.15 normal, tangent and bitangent once
// its upper neighbor is in, the last row as it completes. An item yields zero
// to three vertices. Each vertex is popped and reads its five store taps, then
// takes two passes of one shared normalizer (squares, scaling, a bit-serial
// square root and a bit-serial divider per component), then the cross product
// and the output load, which waits out any output stall. A height is taken
// only when no queued vertex still has store reads to do, so the next height is
// accepted while the previous vertex computes.
// Configuration is a plain write port: index 0 grid resolution (clamped to
// 1..64), index 1 spacing (zero acts as one); write only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module heightmap_vertex_normals (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [hvn_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [hvn_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [hvn_pkg::H_W-1:0]     height_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [hvn_pkg::COORD_W-1:0]        grid_x_o,
  output logic [hvn_pkg::COORD_W-1:0]        grid_z_o,
  output logic signed [hvn_pkg::H_W-1:0]     vertex_height_o,
  output logic signed [hvn_pkg::V_W-1:0]     normal_x_o,
  output logic signed [hvn_pkg::V_W-1:0]     normal_y_o,
  output logic signed [hvn_pkg::V_W-1:0]     normal_z_o,
  output logic signed [hvn_pkg::V_W-1:0]     tangent_x_o,
  output logic signed [hvn_pkg::V_W-1:0]     tangent_y_o,
  output logic signed [hvn_pkg::V_W-1:0]     bitangent_x_o,
  output logic signed [hvn_pkg::V_W-1:0]     bitangent_y_o,
  output logic signed [hvn_pkg::V_W-1:0]     bitangent_z_o,
  output logic                               final_vertex_o
);
  import hvn_pkg::*;

  // configuration registers
  logic [COORD_W-1:0] grid_res_q;
  logic [SP_W-1:0]    spacing_q;
  logic [COORD_W-1:0] res_eff;
  logic [SP_W-1:0]    spacing_eff;

  // front to queue to back
  logic       push;
  cmd_t       push_cmd;
  cmd_t       pop_cmd;
  logic       pop;
  fifo_stat_t fifo_stat;
  logic       rd_busy;

  // line store ports
  logic                  wr_en;
  logic [ADDR_W-1:0]     wr_addr;
  logic signed [H_W-1:0] wr_data;
  logic                  rd_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic signed [H_W-1:0] rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_res_q <= GRID_RES_RESET;
      spacing_q  <= SPACING_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_RES: grid_res_q <= cfg_wdata_i[COORD_W-1:0];
        REG_SPACING:  spacing_q  <= cfg_wdata_i[SP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // out-of-range resolution clamps, zero spacing acts as one
  always_comb begin
    if (grid_res_q == '0) begin
      res_eff = COORD_W'(1);
    end else if (grid_res_q > COORD_W'(MAX_RES)) begin
      res_eff = COORD_W'(MAX_RES);
    end else begin
      res_eff = grid_res_q;
    end
  end

  assign spacing_eff = (spacing_q == '0) ? SP_W'(1) : spacing_q;

  hvn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .height_i    (height_i),
    .res_i       (res_eff),
    .fifo_stat_i (fifo_stat),
    .rd_busy_i   (rd_busy),
    .push_o      (push),
    .cmd_o       (push_cmd),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data)
  );

  hvn_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (pop_cmd),
    .stat_o (fifo_stat)
  );

  hvn_line_store u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  hvn_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .fifo_empty_i    (fifo_stat.empty),
    .pop_o           (pop),
    .cmd_i           (pop_cmd),
    .spacing_i       (spacing_eff),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr),
    .rd_data_i       (rd_data),
    .rd_busy_o       (rd_busy),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .grid_x_o        (grid_x_o),
    .grid_z_o        (grid_z_o),
    .vertex_height_o (vertex_height_o),
    .normal_x_o      (normal_x_o),
    .normal_y_o      (normal_y_o),
    .normal_z_o      (normal_z_o),
    .tangent_x_o     (tangent_x_o),
    .tangent_y_o     (tangent_y_o),
    .bitangent_x_o   (bitangent_x_o),
    .bitangent_y_o   (bitangent_y_o),
    .bitangent_z_o   (bitangent_z_o),
    .final_vertex_o  (final_vertex_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/hvn_line_store.sv =====
// ----------------------------------------------------------------------------
// hvn_line_store
// three-row height store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hvn_line_store (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [hvn_pkg::ADDR_W-1:0]       wr_addr_i,
  input  logic signed [hvn_pkg::H_W-1:0]   wr_data_i,
  input  logic                             rd_en_i,
  input  logic [hvn_pkg::ADDR_W-1:0]       rd_addr_i,
  output logic signed [hvn_pkg::H_W-1:0]   rd_data_o
);
  import hvn_pkg::*;

  logic signed [H_W-1:0] mem_q [STORE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hvn_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// hvn_cmd_fifo
// short vertex command queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module hvn_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hvn_pkg::cmd_t       cmd_i,
  input  logic                pop_i,
  output hvn_pkg::cmd_t       cmd_o,
  output hvn_pkg::fifo_stat_t stat_o
);
  import hvn_pkg::*;

  cmd_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]   cnt_q;
  logic                  do_push, do_pop;

  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign cmd_o        = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hvn_front.sv =====
// ----------------------------------------------------------------------------
// hvn_front
// takes heights, tracks the raster position and queues vertices to emit
// ----------------------------------------------------------------------------
`default_nettype none

module hvn_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic signed [hvn_pkg::H_W-1:0]   height_i,
  input  logic [hvn_pkg::COORD_W-1:0]      res_i,
  input  hvn_pkg::fifo_stat_t              fifo_stat_i,
  input  logic                             rd_busy_i,
  output logic                             push_o,
  output hvn_pkg::cmd_t                    cmd_o,
  output logic                             wr_en_o,
  output logic [hvn_pkg::ADDR_W-1:0]       wr_addr_o,
  output logic signed [hvn_pkg::H_W-1:0]   wr_data_o
);
  import hvn_pkg::*;

  localparam int PEND_UP   = 0;
  localparam int PEND_LEFT = 1;
  localparam int PEND_FIN  = 2;

  logic [COORD_W-1:0] col_q, col_d, row_q, row_d;
  slot_t              rslot_q, rslot_d;
  logic [2:0]         pend_q, pend_d;
  logic [COORD_W-1:0] ix_q, iz_q, ires_q;
  slot_t              islot_q;

  logic               restart, accept;
  logic [COORD_W-1:0] cur_x, cur_z;
  slot_t              cur_slot;

  // position wraps when the grid shrank below it
  assign restart  = (col_q > res_i) || (row_q > res_i);
  assign cur_x    = restart ? '0 : col_q;
  assign cur_z    = restart ? '0 : row_q;
  assign cur_slot = restart ? '0 : rslot_q;

  // no store write while earlier vertices still read
  assign in_stall_o = (pend_q != '0) || !fifo_stat_i.empty || rd_busy_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign wr_en_o   = accept;
  assign wr_addr_o = slot_addr(cur_slot, cur_x);
  assign wr_data_o = height_i;

  assign push_o = (pend_q != '0) && !fifo_stat_i.full;

  always_comb begin
    cmd_o       = '0;
    cmd_o.res   = ires_q;
    cmd_o.zslot = islot_q;
    priority if (pend_q[PEND_UP]) begin
      cmd_o.x     = ix_q;
      cmd_o.z     = iz_q - 1'b1;
      cmd_o.zslot = slot_dec(islot_q);
    end else if (pend_q[PEND_LEFT]) begin
      cmd_o.x = ix_q - 1'b1;
      cmd_o.z = iz_q;
    end else begin
      cmd_o.x   = ires_q;
      cmd_o.z   = ires_q;
      cmd_o.fin = 1'b1;
    end
  end

  always_comb begin
    pend_d  = pend_q;
    col_d   = col_q;
    row_d   = row_q;
    rslot_d = rslot_q;
    if (accept) begin
      pend_d[PEND_UP]   = (cur_z != '0);
      pend_d[PEND_LEFT] = (cur_z == res_i) && (cur_x != '0);
      pend_d[PEND_FIN]  = (cur_z == res_i) && (cur_x == res_i);
      if (cur_x == res_i) begin
        col_d = '0;
        if (cur_z == res_i) begin
          row_d   = '0;
          rslot_d = '0;
        end else begin
          row_d   = cur_z + 1'b1;
          rslot_d = slot_inc(cur_slot);
        end
      end else begin
        col_d   = cur_x + 1'b1;
        row_d   = cur_z;
        rslot_d = cur_slot;
      end
    end else if (push_o) begin
      pend_d = pend_q & (pend_q - 3'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      rslot_q <= '0;
      pend_q  <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      rslot_q <= rslot_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ix_q    <= cur_x;
      iz_q    <= cur_z;
      ires_q  <= res_i;
      islot_q <= cur_slot;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hvn_back.sv =====
// ----------------------------------------------------------------------------
// hvn_back
// per-vertex sequencer: neighbor reads, normalize, cross product, result
// ----------------------------------------------------------------------------
`default_nettype none

module hvn_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             fifo_empty_i,
  output logic                             pop_o,
  input  hvn_pkg::cmd_t                    cmd_i,
  input  logic [hvn_pkg::SP_W-1:0]         spacing_i,
  output logic                             rd_en_o,
  output logic [hvn_pkg::ADDR_W-1:0]       rd_addr_o,
  input  logic signed [hvn_pkg::H_W-1:0]   rd_data_i,
  output logic                             rd_busy_o,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [hvn_pkg::COORD_W-1:0]      grid_x_o,
  output logic [hvn_pkg::COORD_W-1:0]      grid_z_o,
  output logic signed [hvn_pkg::H_W-1:0]   vertex_height_o,
  output logic signed [hvn_pkg::V_W-1:0]   normal_x_o,
  output logic signed [hvn_pkg::V_W-1:0]   normal_y_o,
  output logic signed [hvn_pkg::V_W-1:0]   normal_z_o,
  output logic signed [hvn_pkg::V_W-1:0]   tangent_x_o,
  output logic signed [hvn_pkg::V_W-1:0]   tangent_y_o,
  output logic signed [hvn_pkg::V_W-1:0]   bitangent_x_o,
  output logic signed [hvn_pkg::V_W-1:0]   bitangent_y_o,
  output logic signed [hvn_pkg::V_W-1:0]   bitangent_z_o,
  output logic                             final_vertex_o
);
  import hvn_pkg::*;

  localparam logic [2:0] TAP_C  = 3'd0;
  localparam logic [2:0] TAP_L  = 3'd1;
  localparam logic [2:0] TAP_R  = 3'd2;
  localparam logic [2:0] TAP_D  = 3'd3;
  localparam logic [2:0] TAP_U  = 3'd4;
  localparam logic [2:0] N_TAPS = 3'd5;

  localparam logic [63:0] Q_FLOOR = 64'd1 << 60;
  localparam logic [63:0] SQ_TOP  = 64'd1 << 62;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_PREP, ST_SQUARE, ST_SCALE, ST_SQRT,
    ST_DIV_INIT, ST_DIV, ST_CROSS, ST_OUT
  } state_e;

  state_e                state_q;
  cmd_t                  cmd_q;
  logic [2:0]            rd_cnt_q;
  logic signed [H_W-1:0] h_q [5];
  logic signed [24:0]    vec_q [3];
  logic                  pass_q;
  logic [1:0]            comp_q;
  logic [63:0]           q_q, root_q, bit_q;
  logic [4:0]            m_q;
  logic [47:0]           rem_q;
  logic [46:0]           den_q;
  logic [15:0]           quo_q;
  logic [3:0]            step_q;
  logic signed [V_W-1:0] nrm_q [3];
  logic signed [V_W-1:0] tan_q [2];
  logic signed [31:0]    prod_q, acc_q;
  logic [2:0]            cr_cnt_q;
  logic signed [V_W-1:0] bx_q, by_q, bz_q;

  logic [24:0]           mag_sel;
  logic [49:0]           sq;
  logic [63:0]           sq_try;
  logic [47:0]           num;
  logic                  rem_ge;
  logic [15:0]           quo_nx;
  logic [16:0]           neg_quo;
  logic signed [V_W-1:0] comp_val;
  logic                  last_comp;
  logic signed [V_W-1:0] op_a, op_b;
  logic signed [31:0]    prod_nx;
  slot_t                 rd_slot;
  logic [COORD_W-1:0]    rd_x;

  function automatic logic [24:0] mag25(logic signed [24:0] v);
    return v[24] ? 25'(-v) : 25'(v);
  endfunction

  // Q2.30 to Q1.15, half toward plus infinity, saturated
  function automatic logic signed [V_W-1:0] rnd_q15(logic signed [32:0] p);
    logic signed [33:0] t;
    logic signed [18:0] r;
    t = 34'(p) + 34'sd16384;
    r = 19'(t >>> 15);
    if (r > 19'sd32767) begin
      return 16'sh7fff;
    end
    if (r < -19'sd32768) begin
      return 16'sh8000;
    end
    return 16'(r);
  endfunction

  assign pop_o     = (state_q == ST_IDLE) && !fifo_empty_i;
  assign rd_busy_o = (state_q == ST_READ);

  // neighbor outside the grid reads the center
  always_comb begin
    rd_slot = cmd_q.zslot;
    rd_x    = cmd_q.x;
    unique case (rd_cnt_q)
      TAP_L: begin
        if (cmd_q.x != '0) rd_x = cmd_q.x - 1'b1;
      end
      TAP_R: begin
        if (cmd_q.x < cmd_q.res) rd_x = cmd_q.x + 1'b1;
      end
      TAP_D: begin
        if (cmd_q.z != '0) rd_slot = slot_dec(cmd_q.zslot);
      end
      TAP_U: begin
        if (cmd_q.z < cmd_q.res) rd_slot = slot_inc(cmd_q.zslot);
      end
      default: begin
      end
    endcase
  end

  assign rd_en_o   = (state_q == ST_READ) && (rd_cnt_q < N_TAPS);
  assign rd_addr_o = slot_addr(rd_slot, rd_x);

  assign mag_sel = mag25(vec_q[comp_q]);
  assign sq      = mag_sel * mag_sel;
  assign sq_try  = root_q + bit_q;
  assign num     = ({23'd0, mag_sel} << (6'd15 + {1'b0, m_q})) + {17'd0, root_q[31:1]};
  assign rem_ge  = rem_q >= {1'b0, den_q};
  assign quo_nx  = {quo_q[14:0], rem_ge};
  assign neg_quo = 17'd0 - {1'b0, quo_nx};

  always_comb begin
    if (vec_q[comp_q][24]) begin
      comp_val = (quo_nx > 16'd32768) ? 16'sh8000 : $signed(neg_quo[15:0]);
    end else begin
      comp_val = (quo_nx > 16'd32767) ? 16'sh7fff : $signed(quo_nx);
    end
  end

  assign last_comp = pass_q ? (comp_q == 2'd1) : (comp_q == 2'd2);

  always_comb begin
    unique case (cr_cnt_q)
      3'd0:    begin op_a = nrm_q[2]; op_b = tan_q[1]; end
      3'd1:    begin op_a = nrm_q[2]; op_b = tan_q[0]; end
      3'd2:    begin op_a = nrm_q[0]; op_b = tan_q[1]; end
      default: begin op_a = nrm_q[1]; op_b = tan_q[0]; end
    endcase
  end

  assign prod_nx = op_a * op_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i && (state_q != ST_OUT)) begin
        out_valid_o <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!fifo_empty_i) begin
            cmd_q    <= cmd_i;
            rd_cnt_q <= '0;
            state_q  <= ST_READ;
          end
        end
        ST_READ: begin
          if (rd_cnt_q != '0) begin
            h_q[rd_cnt_q - 3'd1] <= rd_data_i;
          end
          rd_cnt_q <= rd_cnt_q + 3'd1;
          if (rd_cnt_q == N_TAPS) begin
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          vec_q[0] <= 25'(h_q[TAP_L]) - 25'(h_q[TAP_R]);
          vec_q[1] <= $signed({2'b00, spacing_i});
          vec_q[2] <= 25'(h_q[TAP_D]) - 25'(h_q[TAP_U]);
          pass_q   <= 1'b0;
          comp_q   <= '0;
          q_q      <= '0;
          m_q      <= '0;
          state_q  <= ST_SQUARE;
        end
        ST_SQUARE: begin
          q_q <= q_q + 64'(sq);
          if (comp_q == 2'd2) begin
            comp_q  <= '0;
            state_q <= ST_SCALE;
          end else begin
            comp_q <= comp_q + 2'd1;
          end
        end
        ST_SCALE: begin
          if (q_q < Q_FLOOR) begin
            q_q <= q_q << 2;
            m_q <= m_q + 5'd1;
          end else begin
            root_q  <= '0;
            bit_q   <= SQ_TOP;
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          if (q_q >= sq_try) begin
            q_q    <= q_q - sq_try;
            root_q <= (root_q >> 1) + bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (bit_q == 64'd1) begin
            comp_q  <= '0;
            state_q <= ST_DIV_INIT;
          end
        end
        ST_DIV_INIT: begin
          rem_q   <= num;
          den_q   <= {root_q[31:0], 15'd0};
          quo_q   <= '0;
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (rem_ge) begin
            rem_q <= rem_q - {1'b0, den_q};
          end
          den_q  <= den_q >> 1;
          quo_q  <= quo_nx;
          step_q <= step_q + 4'd1;
          if (step_q == 4'd15) begin
            if (!pass_q) begin
              nrm_q[comp_q] <= comp_val;
            end else begin
              tan_q[comp_q[0]] <= comp_val;
            end
            if (!last_comp) begin
              comp_q  <= comp_q + 2'd1;
              state_q <= ST_DIV_INIT;
            end else if (!pass_q) begin
              // tangent direction (s, -a, 0)
              vec_q[0] <= vec_q[1];
              vec_q[1] <= -vec_q[0];
              vec_q[2] <= '0;
              pass_q   <= 1'b1;
              comp_q   <= '0;
              q_q      <= '0;
              m_q      <= '0;
              state_q  <= ST_SQUARE;
            end else begin
              cr_cnt_q <= '0;
              state_q  <= ST_CROSS;
            end
          end
        end
        ST_CROSS: begin
          prod_q   <= prod_nx;
          cr_cnt_q <= cr_cnt_q + 3'd1;
          unique case (cr_cnt_q)
            3'd1:    bx_q  <= rnd_q15(-33'(prod_q));
            3'd2:    by_q  <= rnd_q15(33'(prod_q));
            3'd3:    acc_q <= prod_q;
            3'd4:    bz_q  <= rnd_q15(33'(acc_q) - 33'(prod_q));
            default: begin
            end
          endcase
          if (cr_cnt_q == 3'd4) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_o || !out_stall_i) begin
            out_valid_o     <= 1'b1;
            grid_x_o        <= cmd_q.x;
            grid_z_o        <= cmd_q.z;
            vertex_height_o <= h_q[TAP_C];
            normal_x_o      <= nrm_q[0];
            normal_y_o      <= nrm_q[1];
            normal_z_o      <= nrm_q[2];
            tangent_x_o     <= tan_q[0];
            tangent_y_o     <= tan_q[1];
            bitangent_x_o   <= bx_q;
            bitangent_y_o   <= by_q;
            bitangent_z_o   <= bz_q;
            final_vertex_o  <= cmd_q.fin;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hvn_checker.sv =====
// ----------------------------------------------------------------------------
// hvn_checker
// port-level checks of the heightmap vertex normal block, bound to the top
// ----------------------------------------------------------------------------
`default_nettype none

`include "heightmap_vertex_normals_assert.svh"

module hvn_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [hvn_pkg::COORD_W-1:0]        grid_x_o,
  input logic [hvn_pkg::COORD_W-1:0]        grid_z_o,
  input logic signed [hvn_pkg::V_W-1:0]     normal_x_o,
  input logic signed [hvn_pkg::V_W-1:0]     normal_y_o,
  input logic signed [hvn_pkg::V_W-1:0]     tangent_x_o,
  input logic                               final_vertex_o
);

  // stalled result keeps its payload
  `HVN_ASSERT_CLK(a_out_hold, out_valid_o && out_stall_i |=> $stable(grid_x_o) && $stable(normal_x_o) && $stable(final_vertex_o), "stalled item changed")

  // spacing is positive, so normal y and tangent x never go negative
  `HVN_ASSERT_CLK(a_pos_terms, out_valid_o |-> (normal_y_o >= 0) && (tangent_x_o >= 0), "negative normal y or tangent x")

  // the final vertex is the grid corner
  `HVN_ASSERT_CLK(a_fin_corner, out_valid_o && final_vertex_o |-> (grid_x_o == grid_z_o) && (grid_x_o != 0), "final vertex off the corner")

  // coordinates stay inside the largest grid
  `HVN_ASSERT_CLK(a_coord_range, out_valid_o |-> (grid_x_o <= 7'd64) && (grid_z_o <= 7'd64), "coordinate out of grid")

endmodule

bind heightmap_vertex_normals hvn_checker u_hvn_checker (.*);

`default_nettype wire
